[design/crht_pkg.sv]
// Shared constants, types and controller/datapath interface structs of the clip rectangle table.
`default_nettype none

package crht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam bit IS_POW2     = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

    localparam int KEY_W    = 128;
    localparam int IDX_W    = 9;
    localparam int STATUS_W = 3;
    localparam int HASH_W   = 32;
    localparam int STEP_W   = 5;
    localparam int OUT_W    = 16;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

    // Rounded-up reciprocal of the depth; the quotient of any 32-bit hash is exact with it.
    localparam int              RED_SHIFT = HASH_W + SLOT_W;
    localparam logic [HASH_W:0] RECIP     =
        (HASH_W+1)'(((64'd1 << RED_SHIFT) + 64'(TABLE_DEPTH - 1)) / 64'(TABLE_DEPTH));

    localparam logic [IDX_W-1:0]  NO_SLOT     = '1;
    localparam logic [SLOT_W-1:0] SLOT_MAX    = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [STEP_W-1:0] HASH_LAST   = STEP_W'(15);
    localparam logic [STEP_W-1:0] REDUCE_LAST = STEP_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_REUSED   = 3'd1,
        ST_FOUND    = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FAST_RD,
        S_FAST_CMP,
        S_HASH,
        S_REDUCE,
        S_SEED,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    clr_write;
        logic    hash_step;
        logic    reduce_start;
        logic    reduce_step;
        logic    seed;
        logic    probe_next;
        logic    write_key;
        logic    hit;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic seen;
        logic key_eq;
        logic slot_empty;
        logic hash_last;
        logic reduce_last;
        logic slot_last;
        logic probe_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[design/crht_datapath.sv]
// Datapath of the clip rectangle table: key, FNV-1a hash, slot reduction, table memory, result.
`default_nettype none

module crht_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire crht_pkg::t_dp_cmd        i_cmd,
    output crht_pkg::t_dp_stat            o_stat,
    input  wire logic                     i_opcode,
    input  wire logic [crht_pkg::KEY_W-1:0] i_key,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [crht_pkg::IDX_W-1:0]    o_out_index,
    output logic [crht_pkg::STATUS_W-1:0] o_out_status
);
    import crht_pkg::*;

    logic [KEY_W-1:0]  r_table [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_rdata;
    logic [KEY_W-1:0]  r_key;
    logic [HASH_W-1:0] r_hash;
    logic [STEP_W-1:0] r_step;
    logic [2*HASH_W:0] r_prod;
    logic [SLOT_W-1:0] r_rem;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_probe;
    logic [SLOT_W-1:0] r_last_slot;
    logic              r_seen;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    t_status           r_out_status;

    logic [7:0]              hash_byte;
    logic [HASH_W-1:0]       hash_mix;
    logic [HASH_W-1:0]       hash_next;
    logic [HASH_W-1:0]       quot;
    logic [HASH_W-1:0]       rem_full;
    logic [SLOT_W-1:0]       slot_inc;
    logic [SLOT_W-1:0]       seed_slot;
    logic [SLOT_W+IDX_W-1:0] slot_ext;
    logic                    has_index;

    // Bytes go little-endian from x_min upward, which is the packed key order.
    assign hash_byte = r_key[{r_step[3:0], 3'b000} +: 8];
    assign hash_mix  = r_hash ^ {{(HASH_W-8){1'b0}}, hash_byte};
    assign hash_next = hash_mix * FNV_PRIME;

    // For depths that are not a power of two, the first reduce step forms the product with
    // the reciprocal and the second takes the remainder from the quotient.
    assign quot     = HASH_W'(r_prod >> RED_SHIFT);
    assign rem_full = r_hash - quot * HASH_W'(TABLE_DEPTH);

    assign seed_slot = IS_POW2 ? r_hash[SLOT_W-1:0] : r_rem;
    assign slot_inc  = (r_slot == SLOT_MAX) ? '0 : r_slot + 1'b1;
    assign slot_ext  = {{IDX_W{1'b0}}, r_slot};
    assign has_index = (i_cmd.out_status == ST_REUSED) || (i_cmd.out_status == ST_FOUND) ||
                       (i_cmd.out_status == ST_INSERTED);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_table[r_slot];
        if (i_cmd.clr_write) begin
            r_table[r_slot] <= '0;
        end else if (i_cmd.write_key) begin
            r_table[r_slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_last_slot <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_slot <= i_opcode ? '0 : r_last_slot;
            end else if (i_cmd.clr_write || i_cmd.probe_next) begin
                r_slot <= slot_inc;
            end else if (i_cmd.seed) begin
                r_slot <= seed_slot;
            end

            if (i_cmd.clr_write) begin
                r_last_slot <= '0;
                r_seen      <= 1'b0;
            end else if (i_cmd.hit) begin
                r_last_slot <= r_slot;
                r_seen      <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key  <= i_key;
            r_hash <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_hash <= hash_next;
        end

        if (i_cmd.accept || i_cmd.reduce_start) begin
            r_step <= '0;
        end else if (i_cmd.hash_step || i_cmd.reduce_step) begin
            r_step <= r_step + 1'b1;
        end

        if (i_cmd.reduce_step) begin
            r_prod <= r_hash * RECIP;
            r_rem  <= rem_full[SLOT_W-1:0];
        end

        if (i_cmd.seed) begin
            r_probe <= '0;
        end else if (i_cmd.probe_next) begin
            r_probe <= r_probe + 1'b1;
        end

        if (i_cmd.out_load) begin
            r_out_index  <= has_index ? slot_ext[IDX_W-1:0] : NO_SLOT;
            r_out_status <= i_cmd.out_status;
        end
    end

    always_comb begin
        o_stat.seen        = r_seen;
        o_stat.key_eq      = (r_rdata == r_key);
        o_stat.slot_empty  = (r_rdata == '0);
        o_stat.hash_last   = (r_step == HASH_LAST);
        o_stat.reduce_last = (r_step == REDUCE_LAST);
        o_stat.slot_last   = (r_slot == SLOT_MAX);
        o_stat.probe_last  = (r_probe == SLOT_MAX);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

[design/crht_ctrl.sv]
// Controller state machine of the clip rectangle table: sequences clear, hash, probe and reply.
`default_nettype none

module crht_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_opcode,
    input  wire logic               i_clip_present,
    input  wire crht_pkg::t_dp_stat i_stat,
    output crht_pkg::t_dp_cmd       o_cmd
);
    import crht_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_clr_reply, n_clr_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_status    <= ST_NONE;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_clr_reply <= n_clr_reply;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_clr_reply = r_clr_reply;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.slot_last) begin
                    n_status = ST_CLEARED;
                    n_state  = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_clr_reply = i_opcode;
                    if (i_opcode) begin
                        n_state = S_CLEAR;
                    end else if (!i_clip_present) begin
                        n_status = ST_NONE;
                        n_state  = S_DONE;
                    end else if (i_stat.seen) begin
                        n_state = S_FAST_RD;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_FAST_RD: n_state = S_FAST_CMP;
            S_FAST_CMP: begin
                if (i_stat.key_eq) begin
                    n_status = ST_REUSED;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_last) begin
                    n_state = IS_POW2 ? S_SEED : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_stat.reduce_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED:     n_state = S_PROBE_RD;
            S_PROBE_RD: n_state = S_PROBE_CMP;
            S_PROBE_CMP: begin
                if (i_stat.slot_empty) begin
                    n_status = ST_INSERTED;
                    n_state  = S_DONE;
                end else if (i_stat.key_eq) begin
                    n_status = ST_FOUND;
                    n_state  = S_DONE;
                end else if (i_stat.probe_last) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_write = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_FAST_RD: ;
            S_FAST_CMP: o_cmd.hit = i_stat.key_eq;
            S_HASH: begin
                o_cmd.hash_step    = 1'b1;
                o_cmd.reduce_start = i_stat.hash_last && !IS_POW2;
            end
            S_REDUCE:   o_cmd.reduce_step = 1'b1;
            S_SEED:     o_cmd.seed = 1'b1;
            S_PROBE_RD: ;
            S_PROBE_CMP: begin
                if (i_stat.slot_empty) begin
                    o_cmd.write_key = 1'b1;
                    o_cmd.hit       = 1'b1;
                end else if (i_stat.key_eq) begin
                    o_cmd.hit = 1'b1;
                end else if (!i_stat.probe_last) begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[design/clip_rect_hash_table.sv]
// Top level of the clip rectangle table, which interns 128-bit clip rectangles into slots.
// Usage:
// The slave channel takes one word per request: tuser selects a lookup or a clear and
// flags whether a clip is present, tdata carries the rectangle. The master channel returns
// one word per request: the 9-bit signed slot index (-1 when there is none) and a status.
// Requests are handled one at a time; a word is accepted only while the controller is idle.
// On the way from acceptance to result, a request without a clip goes straight to the reply, a
// reuse of the last slot takes one table read and compare, and the hashed path runs FNV-1a (one
// byte per cycle through one multiplier), then the remainder steps when the depth is not a
// power of two, then one read and one compare per probed slot, as each probe waits for the
// registered read of the single-port table memory. A clear sweeps every slot before its reply.
// After reset the table is swept to zero, one slot a cycle, and no request is accepted until
// the sweep ends. A finished result waits in an output register; while the receiver stalls,
// the next request is still accepted and worked on, and its result waits until the register
// is free.
`default_nettype none

module clip_rect_hash_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [crht_pkg::KEY_W-1:0]    s_axis_tdata,  // x_min, y_min, x_max, y_max
    input  wire logic [1:0]                    s_axis_tuser,  // opcode, clip_present
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [crht_pkg::OUT_W-1:0]         m_axis_tdata,  // slot_index, zero padding
    output logic [crht_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
    import crht_pkg::*;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IDX_W-1:0] out_index;

    crht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_opcode       (s_axis_tuser[0]),
        .i_clip_present (s_axis_tuser[1]),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    crht_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (s_axis_tuser[0]),
        .i_key        (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_index  (out_index),
        .o_out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_W-IDX_W){1'b0}}, out_index};

endmodule

`default_nettype wire

[design/crht_checker.sv]
// Port-level assertions for the clip rectangle table and the bind that attaches them.
`default_nettype none

module crht_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [crht_pkg::KEY_W-1:0]    s_axis_tdata,
    input wire logic [1:0]                    s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [crht_pkg::OUT_W-1:0]    m_axis_tdata,
    input wire logic [crht_pkg::STATUS_W-1:0] m_axis_tuser
);
    import crht_pkg::*;

    // A result word is held until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_CLEARED)
        else $error("status code out of range");

    // No clip, full table and clear carry no slot.
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NONE || m_axis_tuser == ST_FULL ||
                          m_axis_tuser == ST_CLEARED)
        |-> m_axis_tdata == {{(OUT_W-IDX_W){1'b0}}, NO_SLOT})
        else $error("slot index given where none applies");

    // One request at a time: the input closes right after a word is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // The table sweep after reset blocks input and no result is shown.
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block active right after reset");

endmodule

bind clip_rect_hash_table crht_checker u_crht_checker (.*);

`default_nettype wire

[test/tb_clip_rect_hash_table.sv]
// Self-checking testbench of the clip rectangle table: directed and random requests checked against a local interning predictor.
`timescale 1ns / 1ps

module tb_clip_rect_hash_table;

    import crht_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          DRAIN_WAIT  = 64;
    localparam int          SLOTS       = TABLE_DEPTH;
    localparam int          PHASE_ITEMS = 200;
    localparam logic [31:0] HASH_SEED   = 32'h811C9DC5;
    localparam logic [31:0] HASH_MULT   = 32'h01000193;
    localparam logic [8:0]  SLOT_NONE   = 9'h1FF;
    localparam logic        OP_LOOKUP   = 1'b0;
    localparam logic        OP_CLEAR    = 1'b1;

    // Idle and stall percentages of each traffic phase.
    localparam int SRC_IDLE   [4] = '{0, 81, 0, 15};
    localparam int SINK_STALL [4] = '{0, 0, 81, 15};

    typedef struct {
        logic         op;
        logic         clip;
        logic [127:0] rect;
        int           phase;
    } t_request;

    typedef struct {
        logic [8:0] slot;
        t_status    status;
    } t_slot_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Predictor state.
    logic [127:0] rect_store [SLOTS];
    int           last_slot;
    bit           lookup_seen;

    t_request     pending_reqs [$];
    t_slot_result results_due  [$];
    t_request     cur_req;
    int           gen_phase;
    int           cur_phase;
    logic         word_taken;
    int           cycle_count;
    int           mismatches;
    int           results_checked;
    int           status_hits [6];

    clip_rect_hash_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // FNV-1a over the 16 rectangle bytes, x_min first, each lane little-endian.
    function automatic logic [31:0] rect_fnv1a(input logic [127:0] rect);
        logic [31:0] h;
        h = HASH_SEED;
        for (int b = 0; b < 16; b++) begin
            h = (h ^ {24'h0, rect[8*b +: 8]}) * HASH_MULT;
        end
        return h;
    endfunction

    function automatic void wipe_store();
        for (int s = 0; s < SLOTS; s++) begin
            rect_store[s] = '0;
        end
        last_slot   = 0;
        lookup_seen = 1'b0;
    endfunction

    function automatic t_slot_result intern_rect(input t_request rq);
        t_slot_result r;
        int           probe;
        r.slot   = SLOT_NONE;
        r.status = ST_NONE;
        if (rq.op == OP_CLEAR) begin
            wipe_store();
            r.status = ST_CLEARED;
            return r;
        end
        if (!rq.clip) begin
            return r;
        end
        if (lookup_seen && rect_store[last_slot] == rq.rect) begin
            r.slot   = 9'(last_slot);
            r.status = ST_REUSED;
            return r;
        end
        probe    = int'(rect_fnv1a(rq.rect) % SLOTS);
        r.status = ST_FULL;
        for (int n = 0; n < SLOTS && r.status == ST_FULL; n++) begin
            if (rect_store[probe] == '0) begin
                rect_store[probe] = rq.rect;
                r.status = ST_INSERTED;
            end else if (rect_store[probe] == rq.rect) begin
                r.status = ST_FOUND;
            end else begin
                probe = (probe + 1) % SLOTS;
            end
        end
        if (r.status != ST_FULL) begin
            last_slot   = probe;
            lookup_seen = 1'b1;
            r.slot      = 9'(probe);
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_request(input logic op, input logic clip, input logic [127:0] rect);
        t_request rq;
        rq.op    = op;
        rq.clip  = clip;
        rq.rect  = rect;
        rq.phase = gen_phase;
        pending_reqs.push_back(rq);
    endtask

    // Lanes mix plain random values, the extremes and float-like coordinates.
    function automatic logic [127:0] rand_rect();
        logic [127:0] rect;
        int           roll;
        for (int w = 0; w < 4; w++) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                rect[32*w +: 32] = $urandom;
            end else if (roll < 80) begin
                rect[32*w +: 32] = 32'h0;
            end else if (roll < 90) begin
                rect[32*w +: 32] = 32'hFFFF_FFFF;
            end else begin
                rect[32*w +: 32] = {1'b0, 8'($urandom_range(127, 137)), 23'($urandom)};
            end
        end
        return rect;
    endfunction

    // Driver: a word stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || word_taken) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= SRC_IDLE[pending_reqs[0].phase]) begin
                    cur_req   = pending_reqs.pop_front();
                    cur_phase = cur_req.phase;
                    s_axis_tdata  <= cur_req.rect;
                    s_axis_tuser  <= {cur_req.clip, cur_req.op};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= SINK_STALL[cur_phase]);
        end
    end

    // Monitor: checks results first, since no result can leave in the cycle its request enters.
    always @(posedge i_clk) begin
        t_slot_result want;
        cycle_count++;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result slot %0h status %0d",
                                            m_axis_tdata, m_axis_tuser));
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    status_hits[want.status]++;
                    if (m_axis_tdata !== {{(OUT_W-IDX_W){1'b0}}, want.slot})
                        flag_mismatch($sformatf("slot_index got %0h want %0h (%s)",
                                                m_axis_tdata, want.slot, want.status.name()));
                    if (m_axis_tuser !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                m_axis_tuser, want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(intern_rect(cur_req));
            end
            word_taken <= s_axis_tvalid && s_axis_tready;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [127:0] pool [$];
        logic [127:0] pick;
        logic [127:0] key_a;
        logic [127:0] key_b;
        int           frame_len;
        int           phase_start;
        int           roll;
        int           p;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cur_phase     = 0;
        gen_phase     = 0;
        cycle_count   = 0;
        mismatches    = 0;
        word_taken    = 1'b0;
        cur_req       = '{OP_LOOKUP, 1'b0, '0, 0};
        wipe_store();

        // Directed part: no clip, zero and all-ones keys, reuse, found, clears.
        key_a = {96'h0, 32'hFFFF_FFFF};
        key_b = {32'h8000_0000, 96'h0};
        queue_request(OP_LOOKUP, 1'b0, '0);
        queue_request(OP_LOOKUP, 1'b1, '0);
        queue_request(OP_LOOKUP, 1'b1, '0);
        queue_request(OP_LOOKUP, 1'b1, '1);
        queue_request(OP_LOOKUP, 1'b1, '1);
        queue_request(OP_LOOKUP, 1'b1, '0);
        queue_request(OP_LOOKUP, 1'b1, key_a);
        queue_request(OP_LOOKUP, 1'b1, key_b);
        queue_request(OP_LOOKUP, 1'b1, key_a);
        queue_request(OP_LOOKUP, 1'b0, '1);
        queue_request(OP_LOOKUP, 1'b1, key_b);
        queue_request(OP_LOOKUP, 1'b1, key_b);
        queue_request(OP_CLEAR,  1'b1, '1);
        queue_request(OP_LOOKUP, 1'b1, key_b);
        queue_request(OP_CLEAR,  1'b0, '0);
        queue_request(OP_CLEAR,  1'b0, key_a);
        queue_request(OP_LOOKUP, 1'b1, {32'h3F80_0000, 32'h3F80_0000, 32'h0, 32'h0});
        queue_request(OP_LOOKUP, 1'b1, {32'h4487_0000, 32'h44F0_0000, 32'h0, 32'h0});
        queue_request(OP_LOOKUP, 1'b1, {32'h3F80_0000, 32'h3F80_0000, 32'h0, 32'h0});

        // Random part: frames of lookups over a small pool of rectangles, each opened by a clear.
        for (p = 0; p < 4; p++) begin
            gen_phase   = p;
            phase_start = pending_reqs.size();
            if (p == 2) begin
                // One frame fills the whole table, then runs into the full case.
                queue_request(OP_CLEAR, 1'($urandom_range(1)), rand_rect());
                pool.delete();
                repeat (SLOTS + 8) begin
                    pick = {$urandom, $urandom, $urandom, $urandom} | 128'h1;
                    pool.push_back(pick);
                    queue_request(OP_LOOKUP, 1'b1, pick);
                end
                queue_request(OP_LOOKUP, 1'b0, rand_rect());
                queue_request(OP_LOOKUP, 1'b1, '0);
                repeat (24) begin
                    queue_request(OP_LOOKUP, 1'b1, pool[$urandom_range(pool.size() - 1)]);
                end
                queue_request(OP_CLEAR, 1'($urandom_range(1)), rand_rect());
            end
            while (pending_reqs.size() - phase_start < PHASE_ITEMS) begin
                queue_request(OP_CLEAR, 1'($urandom_range(1)), rand_rect());
                pool.delete();
                repeat ($urandom_range(1, 12)) pool.push_back(rand_rect());
                pick      = pool[0];
                frame_len = $urandom_range(5, 40);
                repeat (frame_len) begin
                    roll = $urandom_range(99);
                    if (roll < 82) begin
                        if (roll >= 40) pick = pool[$urandom_range(pool.size() - 1)];
                        queue_request(OP_LOOKUP, 1'b1, pick);
                    end else if (roll < 88) begin
                        queue_request(OP_LOOKUP, 1'b0, rand_rect());
                    end else if (roll < 91) begin
                        queue_request(OP_LOOKUP, 1'b1, '0);
                    end else if (roll < 94) begin
                        queue_request(OP_CLEAR, 1'($urandom_range(1)), rand_rect());
                    end else begin
                        pick = rand_rect();
                        pool.push_back(pick);
                        queue_request(OP_LOOKUP, 1'b1, pick);
                    end
                end
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_axis_tvalid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d results in %0d cycles: %0d inserted, %0d found, %0d reused,",
                 results_checked, cycle_count, status_hits[ST_INSERTED],
                 status_hits[ST_FOUND], status_hits[ST_REUSED]);
        $display("  %0d full-table misses, %0d without clip, %0d clears, %0d mismatches",
                 status_hits[ST_FULL], status_hits[ST_NONE], status_hits[ST_CLEARED],
                 mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
